// ===== rtl/csdb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the cubic B-spline evaluator.
// No dependencies; imported by the controller, datapath and top level.
package csdb_pkg;

	// func field codes
	localparam logic [1:0] FUNC_WR_KNOT = 2'd0;
	localparam logic [1:0] FUNC_WR_COEF = 2'd1;
	localparam logic [1:0] FUNC_EVAL    = 2'd2;
	localparam logic [1:0] FUNC_DERIV   = 2'd3;

	// Q16.16 blend weight limit (2^29)
	localparam logic signed [51:0] WEIGHT_MAX = 52'sd536870912;
	localparam logic signed [51:0] WEIGHT_MIN = -52'sd536870912;

	typedef enum logic [1:0] {
		ERR_OK   = 2'd0,
		ERR_SPAN = 2'd1,
		ERR_ZERO = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_WRITE,
		OP_LOAD_D,
		OP_DIV_BLEND,
		OP_DIV_DCOEF,
		OP_CLAMP,
		OP_MUL,
		OP_BLEND_WB,
		OP_DCOEF_WB,
		OP_OUTPUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] dsel;
		logic       lat_lo;
		logic       lat_hi;
		logic       lat_ca;
		logic       lat_cb;
	} dp_cmd_t;

	typedef struct packed {
		logic knot_gt;
		logic div_busy;
		logic zero_seen;
		logic out_free;
	} dp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		if (v > 65'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -65'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

// ===== rtl/csdb_div.sv =====
`timescale 1ns / 1ps
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Shared by the blend weights and the differenced coefficients; no dependencies.
module csdb_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [50:0]  num,
	input  logic signed [32:0]  den,
	output logic                busy,
	output logic signed [51:0]  quo
);

	logic        busy_q;
	logic        fin_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [50:0] sh_q;
	logic [32:0] dv_q;
	logic        neg_q;
	logic signed [51:0] quo_q;

	logic [33:0] trial;
	logic        fits;

	assign trial = {rem_q, sh_q[50]};
	assign fits  = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			fin_q  <= 1'b0;
			cnt_q  <= 6'd51;
		end else if (fin_q) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1)
				fin_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num[50] ? 51'(-num) : num;
			dv_q  <= den[32] ? 33'(-den) : den;
			neg_q <= num[50] ^ den[32];
			rem_q <= '0;
		end else if (fin_q) begin
			quo_q <= neg_q ? -$signed({1'b0, sh_q}) : $signed({1'b0, sh_q});
		end else if (busy_q) begin
			rem_q <= fits ? 33'(trial - {1'b0, dv_q}) : trial[32:0];
			sh_q  <= {sh_q[49:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/csdb_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: knot and coefficient tables, de Boor registers, multiplier, output register.
// Depends on csdb_pkg and csdb_div; driven by csdb_ctrl commands.
module csdb_dpath #(
	parameter int MAX_KNOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  csdb_pkg::dp_cmd_t             cmd,
	input  logic [$clog2(MAX_KNOTS)-1:0]  kaddr,
	input  logic [$clog2(MAX_KNOTS)-1:0]  caddr,
	input  csdb_pkg::err_t                out_err,
	input  logic [5:0]                    out_span,
	output csdb_pkg::dp_sts_t             sts,
	input  logic [1:0]                    in_func,
	input  logic [5:0]                    in_index,
	input  logic signed [31:0]            in_value,
	input  logic signed [31:0]            in_point,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            out_result,
	output logic [5:0]                    out_span_index,
	output logic [1:0]                    out_error_code
);
	import csdb_pkg::*;

	localparam int KW = $clog2(MAX_KNOTS);

	logic signed [31:0] knot_mem [MAX_KNOTS];
	logic signed [31:0] coef_mem [MAX_KNOTS];
	logic signed [31:0] knot_rd_q, coef_rd_q;

	logic [1:0]         func_q;
	logic [5:0]         idx_q;
	logic signed [31:0] val_q, x_q;
	logic signed [31:0] lo_q, hi_q, ca_q, cb_q;
	logic signed [31:0] d_q [4];
	logic signed [30:0] a_q;
	logic signed [63:0] prod_q;
	logic               zero_q;
	logic               ovalid_q;
	logic signed [31:0] ores_q;
	logic [5:0]         ospan_q;
	logic [1:0]         oerr_q;

	logic               wr_ok;
	logic [KW-1:0]      widx;
	logic signed [32:0] den;
	logic signed [32:0] xl;
	logic signed [34:0] cd, cd3;
	logic signed [50:0] num;
	logic               div_start, div_busy;
	logic signed [51:0] quo;
	logic signed [31:0] dprev, dcur;
	logic signed [32:0] diff;
	logic signed [48:0] bsum;
	logic signed [31:0] res_sel;

	assign wr_ok = 32'(idx_q) < MAX_KNOTS;
	assign widx  = KW'(idx_q);
	assign den   = 33'(hi_q) - 33'(lo_q);
	assign xl    = 33'(x_q) - 33'(lo_q);
	assign cd    = 35'(ca_q) - 35'(cb_q);
	assign cd3   = cd + (cd <<< 1);
	assign num   = (cmd.op == OP_DIV_DCOEF) ? $signed({cd3, 16'h0000})
	                                        : 51'($signed({xl, 16'h0000}));
	assign div_start = (cmd.op == OP_DIV_BLEND) || (cmd.op == OP_DIV_DCOEF);

	assign dprev = d_q[cmd.dsel - 2'd1];
	assign dcur  = d_q[cmd.dsel];
	assign diff  = 33'(dcur) - 33'(dprev);
	// floor division by 2^16 is an arithmetic shift of the product
	assign bsum  = 49'(dprev) + 49'($signed(prod_q[63:16]));

	csdb_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num),
		.den   (den),
		.busy  (div_busy),
		.quo   (quo)
	);

	// tables: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (cmd.op == OP_WRITE && wr_ok) begin
			if (func_q == FUNC_WR_KNOT)
				knot_mem[widx] <= val_q;
			else
				coef_mem[widx] <= val_q;
		end
		knot_rd_q <= knot_mem[kaddr];
		coef_rd_q <= coef_mem[caddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			func_q <= in_func;
			idx_q  <= in_index;
			val_q  <= in_value;
			x_q    <= in_point;
		end
		if (cmd.lat_lo) lo_q <= knot_rd_q;
		if (cmd.lat_hi) hi_q <= knot_rd_q;
		if (cmd.lat_ca) ca_q <= coef_rd_q;
		if (cmd.lat_cb) cb_q <= coef_rd_q;
		case (cmd.op)
			OP_LOAD_D:   d_q[cmd.dsel] <= coef_rd_q;
			OP_CLAMP: begin
				if (quo > WEIGHT_MAX)
					a_q <= 31'(WEIGHT_MAX);
				else if (quo < WEIGHT_MIN)
					a_q <= 31'(WEIGHT_MIN);
				else
					a_q <= quo[30:0];
			end
			OP_MUL:      prod_q <= 64'(a_q) * 64'(diff);
			OP_BLEND_WB: d_q[cmd.dsel] <= sat32(65'(bsum));
			OP_DCOEF_WB: d_q[cmd.dsel] <= sat32(65'(quo));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 1'b0;
		end else if (cmd.op == OP_CAPTURE) begin
			zero_q <= 1'b0;
		end else if (div_start && den == 33'sd0) begin
			zero_q <= 1'b1;
		end
	end

	// result value: d[3] for the value form, d[2] for the derivative form
	assign res_sel = (func_q == FUNC_DERIV) ? d_q[2] : d_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.op == OP_OUTPUT) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUTPUT) begin
			ores_q  <= (out_err != ERR_OK || !func_q[1]) ? 32'sd0 : res_sel;
			ospan_q <= out_span;
			oerr_q  <= out_err;
		end
	end

	assign sts.knot_gt   = knot_rd_q > x_q;
	assign sts.div_busy  = div_busy;
	assign sts.zero_seen = zero_q;
	assign sts.out_free  = !ovalid_q || out_ready;

	assign out_valid      = ovalid_q;
	assign out_result     = ores_q;
	assign out_span_index = ospan_q;
	assign out_error_code = oerr_q;

endmodule

// ===== rtl/csdb_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: span search, de Boor step sequencing and the knots_in_use register.
// Depends on csdb_pkg; commands csdb_dpath.
module csdb_ctrl #(
	parameter int MAX_KNOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    in_func,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [6:0]                    cfg_data,
	output csdb_pkg::dp_cmd_t             cmd,
	output logic [$clog2(MAX_KNOTS)-1:0]  kaddr,
	output logic [$clog2(MAX_KNOTS)-1:0]  caddr,
	output csdb_pkg::err_t                out_err,
	output logic [5:0]                    out_span,
	input  csdb_pkg::dp_sts_t             sts
);
	import csdb_pkg::*;

	localparam int KW = $clog2(MAX_KNOTS);
	localparam int NW = $clog2(MAX_KNOTS + 1);
	localparam int AW = KW + 2;

	typedef enum logic [4:0] {
		S_IDLE, S_WRITE, S_SCAN_RD, S_SCAN_CMP, S_CHECK,
		S_LD_RD, S_LD_LAT,
		S_DC_RD0, S_DC_RD1, S_DC_LAT, S_DC_DIV, S_DC_WAIT, S_DC_WB,
		S_BL_RLO, S_BL_RHI, S_BL_LHI, S_BL_DIV, S_BL_WAIT, S_BL_CLAMP,
		S_BL_MUL, S_BL_WB, S_FIN
	} state_t;

	state_t        state_q;
	logic [6:0]    knots_q;
	logic [KW-1:0] i_q, k_q;
	logic          kval_q, deriv_q, spanerr_q;
	logic [1:0]    j_q, r_q;

	logic [NW-1:0] n_eff;
	logic [AW-1:0] kx, jx, rx, nx;
	logic [AW-1:0] lo_idx, hi_idx;
	logic [1:0]    jtop;
	logic          span_bad;

	always_comb begin
		if (knots_q < 7'd8)
			n_eff = NW'(8);
		else if (32'(knots_q) > MAX_KNOTS)
			n_eff = NW'(MAX_KNOTS);
		else
			n_eff = NW'(knots_q);
	end

	assign kx = AW'(k_q);
	assign jx = AW'(j_q);
	assign rx = AW'(r_q);
	assign nx = AW'(n_eff);
	assign lo_idx = kx + jx - (deriv_q ? AW'(2) : AW'(3));
	assign hi_idx = kx + jx + AW'(1) - rx;
	assign jtop   = deriv_q ? 2'd2 : 2'd3;
	assign span_bad = !kval_q || kx < AW'(3) || kx + AW'(5) > nx;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_span  = kval_q ? 6'(k_q) : 6'd0;

	always_comb begin
		if (spanerr_q)
			out_err = ERR_SPAN;
		else if (sts.zero_seen)
			out_err = ERR_ZERO;
		else
			out_err = ERR_OK;
	end

	always_comb begin
		cmd   = '{op: OP_NOP, dsel: j_q, lat_lo: 1'b0, lat_hi: 1'b0,
		          lat_ca: 1'b0, lat_cb: 1'b0};
		kaddr = i_q;
		caddr = KW'(kx + jx - AW'(3));
		case (state_q)
			S_IDLE:     if (in_valid) cmd.op = OP_CAPTURE;
			S_WRITE:    cmd.op = OP_WRITE;
			S_LD_LAT:   cmd.op = OP_LOAD_D;
			S_DC_RD0: begin
				caddr = KW'(kx + jx - AW'(2));
				kaddr = KW'(kx + jx + AW'(1));
			end
			S_DC_RD1: begin
				caddr = KW'(kx + jx - AW'(3));
				kaddr = KW'(kx + jx - AW'(2));
				cmd.lat_ca = 1'b1;
				cmd.lat_hi = 1'b1;
			end
			S_DC_LAT: begin
				cmd.lat_cb = 1'b1;
				cmd.lat_lo = 1'b1;
			end
			S_DC_DIV:   cmd.op = OP_DIV_DCOEF;
			S_DC_WB:    cmd.op = OP_DCOEF_WB;
			S_BL_RLO:   kaddr = KW'(lo_idx);
			S_BL_RHI: begin
				kaddr = KW'(hi_idx);
				cmd.lat_lo = 1'b1;
			end
			S_BL_LHI:   cmd.lat_hi = 1'b1;
			S_BL_DIV:   cmd.op = OP_DIV_BLEND;
			S_BL_CLAMP: cmd.op = OP_CLAMP;
			S_BL_MUL:   cmd.op = OP_MUL;
			S_BL_WB:    cmd.op = OP_BLEND_WB;
			S_FIN:      if (sts.out_free) cmd.op = OP_OUTPUT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			knots_q   <= 7'd8;
			i_q       <= '0;
			k_q       <= '0;
			kval_q    <= 1'b0;
			deriv_q   <= 1'b0;
			spanerr_q <= 1'b0;
			j_q       <= '0;
			r_q       <= '0;
		end else begin
			if (cfg_valid)
				knots_q <= cfg_data;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						i_q       <= '0;
						kval_q    <= 1'b0;
						spanerr_q <= 1'b0;
						deriv_q   <= (in_func == FUNC_DERIV);
						state_q   <= in_func[1] ? S_SCAN_RD : S_WRITE;
					end
				end
				S_WRITE:   state_q <= S_FIN;
				S_SCAN_RD: state_q <= S_SCAN_CMP;
				S_SCAN_CMP: begin
					if (sts.knot_gt) begin
						state_q <= S_CHECK;
					end else begin
						k_q    <= i_q;
						kval_q <= 1'b1;
						if (AW'(i_q) == nx - AW'(1)) begin
							state_q <= S_CHECK;
						end else begin
							i_q     <= i_q + KW'(1);
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_CHECK: begin
					j_q <= '0;
					if (span_bad) begin
						spanerr_q <= 1'b1;
						state_q   <= S_FIN;
					end else begin
						state_q <= deriv_q ? S_DC_RD0 : S_LD_RD;
					end
				end
				S_LD_RD:  state_q <= S_LD_LAT;
				S_LD_LAT: begin
					if (j_q == 2'd3) begin
						r_q     <= 2'd1;
						state_q <= S_BL_RLO;
					end else begin
						j_q     <= j_q + 2'd1;
						state_q <= S_LD_RD;
					end
				end
				S_DC_RD0:  state_q <= S_DC_RD1;
				S_DC_RD1:  state_q <= S_DC_LAT;
				S_DC_LAT:  state_q <= S_DC_DIV;
				S_DC_DIV:  state_q <= S_DC_WAIT;
				S_DC_WAIT: if (!sts.div_busy) state_q <= S_DC_WB;
				S_DC_WB: begin
					if (j_q == 2'd2) begin
						r_q     <= 2'd1;
						state_q <= S_BL_RLO;
					end else begin
						j_q     <= j_q + 2'd1;
						state_q <= S_DC_RD0;
					end
				end
				S_BL_RLO:   state_q <= S_BL_RHI;
				S_BL_RHI:   state_q <= S_BL_LHI;
				S_BL_LHI:   state_q <= S_BL_DIV;
				S_BL_DIV:   state_q <= S_BL_WAIT;
				S_BL_WAIT:  if (!sts.div_busy) state_q <= S_BL_CLAMP;
				S_BL_CLAMP: state_q <= S_BL_MUL;
				S_BL_MUL:   state_q <= S_BL_WB;
				S_BL_WB: begin
					if (j_q == r_q) begin
						if (r_q == jtop) begin
							state_q <= S_FIN;
						end else begin
							r_q     <= r_q + 2'd1;
							j_q     <= jtop;
							state_q <= S_BL_RLO;
						end
					end else begin
						j_q     <= j_q - 2'd1;
						state_q <= S_BL_RLO;
					end
				end
				S_FIN: if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/cubic_spline_de_boor_evaluator.sv =====
`timescale 1ns / 1ps
// Cubic B-spline (de Boor) evaluator, Q16.16.
// Input items on s_*: write a knot or coefficient, or evaluate value/derivative at a point.
// Each item yields exactly one result item on m_*: value, knot span index, error code.
// cfg_* writes knots_in_use (used clamped to [8, MAX_KNOTS]); write it only while idle.
// An evaluation compares the knots one by one in a linear search over one table read
// port, then loads the coefficients (for the derivative, three differenced coefficients,
// each formed by a division), then runs the blends (6 blends for the value, 3 for the
// derivative). Each division holds the single shared bit-serial divider for 51 quotient
// steps and a sign fix-up. One item is in flight at a time.
// A span error ends right after the search.
// A result waits in the output register while the next item is taken; if the
// receiver stalls, the block finishes that item and holds before its output.
// Reset clears the controller, the output valid and sets knots_in_use to 8.
// Table contents are not cleared; entries are undefined until written.
module cubic_spline_de_boor_evaluator #(
	parameter int MAX_KNOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // func[1:0], table_index[7:2], table_value[39:8],
	                               // point[71:40]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // result_value[31:0], span_index[37:32],
	                               // error_code[39:38]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data   // knots_in_use
);
	import csdb_pkg::*;

	localparam int KW = $clog2(MAX_KNOTS);

	dp_cmd_t            cmd;
	dp_sts_t            sts;
	logic [KW-1:0]      kaddr, caddr;
	err_t               out_err;
	logic [5:0]         out_span;
	logic signed [31:0] result_value;
	logic [5:0]         span_index;
	logic [1:0]         error_code;

	// sequencer: span search and de Boor step order
	csdb_ctrl #(.MAX_KNOTS(MAX_KNOTS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (s_tdata[1:0]),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.kaddr    (kaddr),
		.caddr    (caddr),
		.out_err  (out_err),
		.out_span (out_span),
		.sts      (sts)
	);

	// tables, divider, multiplier and output register
	csdb_dpath #(.MAX_KNOTS(MAX_KNOTS)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.kaddr         (kaddr),
		.caddr         (caddr),
		.out_err       (out_err),
		.out_span      (out_span),
		.sts           (sts),
		.in_func       (s_tdata[1:0]),
		.in_index      (s_tdata[7:2]),
		.in_value      (s_tdata[39:8]),
		.in_point      (s_tdata[71:40]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_result    (result_value),
		.out_span_index(span_index),
		.out_error_code(error_code)
	);

	assign m_tdata = {error_code, span_index, result_value};

endmodule
